[design/fds_pkg.sv]
// Shared constants, tables and types for the fall detector.
`default_nettype none
package fds_pkg;

  localparam int unsigned SAMPLE_RATE_HZ = 100;
  localparam int unsigned TICK_MS        = 1000 / SAMPLE_RATE_HZ;

  localparam int unsigned MAG_W   = 13;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned NUM_LEVELS = 9;

  // level index 0..8 is sensitivity level 1..9
  localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 4'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd9;
  localparam logic [LEVEL_W-1:0] LV_IDX_RST  = 4'd8;

  localparam int unsigned TICKS_1S = 1000 / TICK_MS;
  localparam int unsigned TICKS_2S = 2000 / TICK_MS;
  localparam int unsigned TICKS_4S = 4000 / TICK_MS;
  localparam int unsigned FF_TICKS_MAX = 345 / TICK_MS;

  localparam int unsigned FF_CNT_W   = $clog2(FF_TICKS_MAX + 2);
  localparam int unsigned IMP_CNT_W  = $clog2(TICKS_1S + 2);
  localparam int unsigned WIN_CNT_W  = $clog2(TICKS_4S + 2);
  // rest count can climb for the whole window
  localparam int unsigned REST_CNT_W = WIN_CNT_W;

  localparam logic [MAG_W-1:0] IMPACT_LEVEL = 13'd2048;  // 2.0 g
  localparam logic [MAG_W:0]   RISE_MIN     = 14'd410;   // just over 0.4 g

  localparam logic [MAG_W-1:0] FF_THRESH [NUM_LEVELS] = '{
    13'd308, 13'd338, 13'd379, 13'd420, 13'd461, 13'd502, 13'd543, 13'd584, 13'd615
  };
  localparam logic [MAG_W-1:0] REST_THRESH [NUM_LEVELS] = '{
    13'd1158, 13'd1178, 13'd1229, 13'd1280, 13'd1332,
    13'd1383, 13'd1434, 13'd1485, 13'd1536
  };
  localparam logic [FF_CNT_W-1:0] FF_TICKS [NUM_LEVELS] = '{
    FF_CNT_W'(345 / TICK_MS), FF_CNT_W'(320 / TICK_MS), FF_CNT_W'(295 / TICK_MS),
    FF_CNT_W'(270 / TICK_MS), FF_CNT_W'(245 / TICK_MS), FF_CNT_W'(220 / TICK_MS),
    FF_CNT_W'(195 / TICK_MS), FF_CNT_W'(170 / TICK_MS), FF_CNT_W'(145 / TICK_MS)
  };

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_IMPACT = 4'b0010,
    PH_REST   = 4'b0100,
    PH_REPORT = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             device_still;
  } sample_t;

endpackage
`default_nettype wire

[design/fds_detector.sv]
// Fall detection state machine: phase and counters, one sample per step.
`default_nettype none
module fds_detector (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire fds_pkg::sample_t             sample,
  input  wire logic [fds_pkg::LEVEL_W-1:0]  lv_idx,
  output logic                              fall
);

  fds_pkg::phase_t                      phase_r, phase_nxt;
  logic [fds_pkg::FF_CNT_W-1:0]         ff_cnt_r, ff_cnt_nxt, ff_inc;
  logic [fds_pkg::IMP_CNT_W-1:0]        imp_cnt_r, imp_cnt_nxt, imp_inc;
  logic [fds_pkg::WIN_CNT_W-1:0]        win_cnt_r, win_cnt_nxt, win_inc;
  logic [fds_pkg::REST_CNT_W-1:0]       rest_cnt_r, rest_cnt_nxt, rest_inc;
  logic [fds_pkg::MAG_W-1:0]            ff_start_r, ff_start_nxt;
  logic [fds_pkg::MAG_W-1:0]            m;
  logic                                 rise_ok;

  assign m        = sample.magnitude;
  assign ff_inc   = ff_cnt_r + 1'b1;
  assign imp_inc  = imp_cnt_r + 1'b1;
  assign win_inc  = win_cnt_r + 1'b1;
  assign rest_inc = rest_cnt_r + 1'b1;
  // m > start and m - start >= 0.4 g
  assign rise_ok  = {1'b0, m} >= ({1'b0, ff_start_r} + fds_pkg::RISE_MIN);

  always_comb begin
    phase_nxt    = phase_r;
    ff_cnt_nxt   = ff_cnt_r;
    imp_cnt_nxt  = imp_cnt_r;
    win_cnt_nxt  = win_cnt_r;
    rest_cnt_nxt = rest_cnt_r;
    ff_start_nxt = ff_start_r;
    fall         = 1'b0;
    case (phase_r)
      fds_pkg::PH_IDLE: begin
        if (m < fds_pkg::FF_THRESH[lv_idx]) begin
          ff_cnt_nxt = ff_inc;
          if (ff_inc >= fds_pkg::FF_TICKS[lv_idx]) begin
            ff_cnt_nxt   = '0;
            imp_cnt_nxt  = '0;
            win_cnt_nxt  = '0;
            rest_cnt_nxt = '0;
            ff_start_nxt = m;
            phase_nxt    = fds_pkg::PH_IMPACT;
          end
        end else begin
          ff_cnt_nxt = '0;
        end
      end
      fds_pkg::PH_IMPACT: begin
        if (m >= fds_pkg::IMPACT_LEVEL) begin
          rest_cnt_nxt = '0;
          phase_nxt    = fds_pkg::PH_REST;
        end else begin
          imp_cnt_nxt = imp_inc;
          if (imp_inc > fds_pkg::IMP_CNT_W'(fds_pkg::TICKS_1S)) begin
            phase_nxt  = fds_pkg::PH_IDLE;
            ff_cnt_nxt = '0;
          end
        end
      end
      fds_pkg::PH_REST: begin
        win_cnt_nxt = win_inc;
        if (win_inc > fds_pkg::WIN_CNT_W'(fds_pkg::TICKS_4S)) begin
          phase_nxt  = fds_pkg::PH_IDLE;
          ff_cnt_nxt = '0;
        end else if (m < fds_pkg::REST_THRESH[lv_idx]) begin
          if (sample.device_still) begin
            rest_cnt_nxt = rest_inc;
            if (rest_inc > fds_pkg::REST_CNT_W'(fds_pkg::TICKS_2S) && rise_ok) begin
              phase_nxt = fds_pkg::PH_REPORT;
            end
          end
        end else if (rest_cnt_r != '0) begin
          rest_cnt_nxt = rest_cnt_r - 1'b1;   // saturates at zero
        end
      end
      fds_pkg::PH_REPORT: begin
        fall       = 1'b1;
        phase_nxt  = fds_pkg::PH_IDLE;
        ff_cnt_nxt = '0;
      end
      default: begin
        phase_nxt  = fds_pkg::PH_IDLE;
        ff_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= fds_pkg::PH_IDLE;
      ff_cnt_r   <= '0;
      imp_cnt_r  <= '0;
      win_cnt_r  <= '0;
      rest_cnt_r <= '0;
      ff_start_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      ff_cnt_r   <= ff_cnt_nxt;
      imp_cnt_r  <= imp_cnt_nxt;
      win_cnt_r  <= win_cnt_nxt;
      rest_cnt_r <= rest_cnt_nxt;
      ff_start_r <= ff_start_nxt;
    end
  end

endmodule
`default_nettype wire

[design/fds_out_buf.sv]
// Two-entry result buffer (output register plus skid) for the fall flag.
`default_nettype none
module fds_out_buf (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire logic push_data,
  output logic      can_push,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      out_data
);

  logic main_v_r, main_v_nxt, main_d_r, main_d_nxt;
  logic skid_v_r, skid_v_nxt, skid_d_r, skid_d_nxt;
  logic pop;

  assign pop       = main_v_r & out_ready;
  assign can_push  = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (pop || !main_v_r) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = push;
        skid_d_nxt = push_data;
      end else begin
        main_v_nxt = push;
        main_d_nxt = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule
`default_nettype wire

[design/fall_detect_state_machine_core.sv]
// Top level of the fall detector: stream ports, level register, detector and result buffer.
`default_nettype none
// Fall detector. One magnitude sample (unsigned Q3.10 g, 1 g = 1024) enters per
// in_ beat and gives exactly one out_ beat carrying the fall flag, in order. The
// detector walks idle (free fall run below the level's threshold for the level's
// time), impact (>= 2 g within 1 s), rest (over 2 s of still samples below
// the level's rest threshold within 4 s, with the sample at least 0.4 g above the
// free-fall start value) and report; the flag is set on the beat after the rest
// condition is met. Timing: one beat per clock sustained while in_tready stays high;
// a sample's state update is done in the cycle it is accepted, and its result is
// registered in the result buffer before it shows on out_. A two-entry result buffer
// keeps in_tready high while one result waits; in_tready drops only once two results
// are waiting, for as long as the consumer leaves them there. Times are in
// samples at 100 Hz. sensitivity_level (1..9, reset 9) is written through cfg_;
// writes of 0 or 10..15 are dropped, and a new level applies from the next beat.
module fall_detect_state_machine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input samples
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [12:0] magnitude, [15:13] zero
  input  wire logic        in_tuser,   // [0] device_still
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] fall_detected, [7:1] zero
  // sensitivity level writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  logic                            in_beat;
  logic                            fall;
  logic                            fall_out;
  logic [fds_pkg::LEVEL_W-1:0]     lv_idx_r, lv_idx_nxt;
  fds_pkg::sample_t                sample;

  assign cfg_ready = 1'b1;
  assign in_beat   = in_tvalid & in_tready;

  assign sample.magnitude    = in_tdata[fds_pkg::MAG_W-1:0];
  assign sample.device_still = in_tuser;

  // level kept as a table index; out-of-range writes leave it alone
  always_comb begin
    lv_idx_nxt = lv_idx_r;
    if (cfg_valid && (cfg_data inside {[fds_pkg::LEVEL_MIN:fds_pkg::LEVEL_MAX]})) begin
      lv_idx_nxt = cfg_data - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_idx_r <= fds_pkg::LV_IDX_RST;
    end else begin
      lv_idx_r <= lv_idx_nxt;
    end
  end

  fds_detector u_detector (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_beat),
    .sample (sample),
    .lv_idx (lv_idx_r),
    .fall   (fall)
  );

  fds_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_beat),
    .push_data (fall),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (fall_out)
  );

  assign out_tdata = {7'd0, fall_out};

endmodule
`default_nettype wire

[verif/fall_detect_state_machine_core_tb.sv]
// Self-checking testbench for the fall detector core: stream stimulus, own detector model.
`timescale 1ns / 100ps
module fall_detect_state_machine_core_tb;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned HOLD_CYCLES  = 80;    // long receiver hold-off, fills the result buffer
  localparam int unsigned SETTLE_CYCLES = 8;

  // clock, reset and block ports; every input known from time zero
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [12:0] magnitude, [15:13] zero
  logic        in_tuser   = 1'b0; // [0] device_still
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [0] fall_detected, [7:1] zero
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data   = '0;

  fall_detect_state_machine_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Detector model: own copy of level and state, stepped once per accepted
  // input beat. Results are pushed in order onto fall_flags_due.
  // ---------------------------------------------------------------------------
  logic [fds_pkg::LEVEL_W-1:0] det_level = fds_pkg::LEVEL_MAX;
  fds_pkg::phase_t             det_phase = fds_pkg::PH_IDLE;
  int unsigned        ff_run    = 0;   // samples so far in the free-fall run
  int unsigned        imp_wait  = 0;   // samples waited for the impact
  int unsigned        rest_win  = 0;   // samples spent in the rest window
  int unsigned        rest_cnt  = 0;   // net still-and-quiet samples
  logic [fds_pkg::MAG_W-1:0]   ff_start  = '0;  // magnitude that ended the free-fall run

  bit fall_flags_due[$];
  fds_pkg::sample_t sample_fifo[$];

  int unsigned queued_total   = 0;  // beats handed to the driver
  int unsigned accepted_total = 0;  // beats taken by the block
  int unsigned mismatches     = 0;

  // idling knobs, set per phase by the stimulus
  bit drv_idle_on = 1'b1;
  bit rx_idle_on  = 1'b1;
  int unsigned hold_reqs    = 0;
  int unsigned holds_served = 0;

  function automatic bit fall_flag_after(input logic [fds_pkg::MAG_W-1:0] m,
                                         input logic still);
    int unsigned lv;
    bit fall;
    lv   = det_level - 1;
    fall = 1'b0;
    case (det_phase)
      fds_pkg::PH_IDLE: begin
        if (m < fds_pkg::FF_THRESH[lv]) begin
          ff_run++;
          if (ff_run >= fds_pkg::FF_TICKS[lv]) begin
            ff_run    = 0;
            imp_wait  = 0;
            rest_win  = 0;
            rest_cnt  = 0;
            ff_start  = m;
            det_phase = fds_pkg::PH_IMPACT;
          end
        end else begin
          ff_run = 0;
        end
      end
      fds_pkg::PH_IMPACT: begin
        if (m >= fds_pkg::IMPACT_LEVEL) begin
          rest_cnt  = 0;
          det_phase = fds_pkg::PH_REST;
        end else begin
          imp_wait++;
          if (imp_wait > fds_pkg::TICKS_1S) begin
            det_phase = fds_pkg::PH_IDLE;
            ff_run    = 0;
          end
        end
      end
      fds_pkg::PH_REST: begin
        rest_win++;
        if (rest_win > fds_pkg::TICKS_4S) begin
          det_phase = fds_pkg::PH_IDLE;
          ff_run    = 0;
        end else if (m < fds_pkg::REST_THRESH[lv]) begin
          if (still) begin
            rest_cnt++;
            // rise over the free-fall start must be at least RISE_MIN
            if (rest_cnt > fds_pkg::TICKS_2S && m > ff_start &&
                int'(m) - int'(ff_start) >= int'(fds_pkg::RISE_MIN))
              det_phase = fds_pkg::PH_REPORT;
          end
        end else if (rest_cnt > 0) begin
          rest_cnt--;  // floors at zero
        end
      end
      default: begin
        // report: flag goes out on the beat after detection
        fall      = 1'b1;
        det_phase = fds_pkg::PH_IDLE;
        ff_run    = 0;
      end
    endcase
    return fall;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input driver: presents queued samples, steps the model on each accepted
  // beat, then idles before the next one when idling is on.
  // in_tvalid gets exactly one NBA per edge.
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk) begin : in_driver
    logic             nvalid;
    fds_pkg::sample_t nxt;
    nvalid = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        fall_flags_due.push_back(fall_flag_after(in_tdata[fds_pkg::MAG_W-1:0], in_tuser));
        accepted_total++;
        nvalid   = 1'b0;
        gap_left = drv_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (!nvalid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_fifo.size() > 0) begin
          nxt = sample_fifo.pop_front();
          in_tdata <= {3'b000, nxt.magnitude};
          in_tuser <= nxt.device_still;
          nvalid   = 1'b1;
        end
      end
    end
    in_tvalid <= nvalid;
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each result beat against the oldest expected flag,
  // stalls after each beat when idling is on, and serves long hold-off requests.
  // ---------------------------------------------------------------------------
  int unsigned rx_wait = 0;

  always @(posedge clk) begin : out_monitor
    logic nready;
    bit   want;
    nready = out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (fall_flags_due.size() == 0) begin
          $error("fall_detected: result beat with nothing expected, got %0d", out_tdata[0]);
          mismatches++;
        end else begin
          want = fall_flags_due.pop_front();
          if (out_tdata[0] !== want) begin
            $error("fall_detected mismatch: expected %0d, got %0d", want, out_tdata[0]);
            mismatches++;
          end
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (hold_reqs != holds_served) begin
        holds_served++;
        rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        nready = 1'b0;
      end else begin
        nready = 1'b1;
      end
    end
    out_tready <= nready;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_sample(input logic [fds_pkg::MAG_W-1:0] m, input logic still);
    fds_pkg::sample_t s;
    s.magnitude    = m;
    s.device_still = still;
    sample_fifo.push_back(s);
    queued_total++;
  endtask

  // block quiet: every queued beat taken and every result seen
  task automatic wait_quiet();
    do @(posedge clk);
    while (accepted_total != queued_total || fall_flags_due.size() != 0);
  endtask

  // level write; out-of-range values are dropped by the block
  task automatic set_level(input logic [fds_pkg::LEVEL_W-1:0] v);
    wait_quiet();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (v >= fds_pkg::LEVEL_MIN && v <= fds_pkg::LEVEL_MAX)
      det_level = v;
  endtask

  initial begin : stimulus
    int unsigned               lv;
    int                        run;
    int unsigned               waits;
    int unsigned               rlen;
    int unsigned               bad_pct;
    logic [fds_pkg::MAG_W-1:0] m;
    logic [fds_pkg::MAG_W-1:0] ff_last;
    bit                        first;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and threshold edges at reset level 9
    add_sample(13'h1FFF, 1'b1);
    add_sample(13'h0000, 1'b0);
    add_sample(fds_pkg::FF_THRESH[fds_pkg::LV_IDX_RST], 1'b1);  // at threshold, not free fall
    add_sample(fds_pkg::IMPACT_LEVEL, 1'b0);
    // exact-length free-fall run at level 9
    for (int i = 0; i < int'(fds_pkg::FF_TICKS[fds_pkg::LV_IDX_RST]); i++) begin
      if (i == 0)
        m = '0;
      else if (i == 1)
        m = fds_pkg::FF_THRESH[fds_pkg::LV_IDX_RST] - 1'b1;
      else
        m = 13'($urandom_range(0, fds_pkg::FF_THRESH[fds_pkg::LV_IDX_RST] - 1));
      add_sample(m, 1'(i % 2));
    end
    add_sample(fds_pkg::IMPACT_LEVEL - 1'b1, 1'b0);   // just short of impact
    add_sample(13'h1FFF, 1'b1);                       // impact, into rest
    // noisy sample with rest count at zero
    add_sample(fds_pkg::REST_THRESH[fds_pkg::LV_IDX_RST], 1'b1);
    // out-of-range writes are dropped, then the level changes mid-detection
    set_level(4'd0);
    set_level(4'd15);
    set_level(4'd10);
    set_level(fds_pkg::LEVEL_MIN);
    add_sample(fds_pkg::REST_THRESH[0] - 1'b1, 1'b1);
    add_sample(fds_pkg::REST_THRESH[0], 1'b0);        // at the new rest threshold, so noisy; quiet at the old level
    add_sample(fds_pkg::REST_THRESH[0], 1'b1);        // rest count floors at zero again

    // random: mostly whole fall sequences with random content, some noise
    first = 1'b1;
    while (queued_total < 24 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0:       set_level(fds_pkg::LEVEL_MIN);
          1:       set_level(fds_pkg::LEVEL_MAX);
          2:       set_level(4'($urandom_range(1, 9)));
          3:       set_level(4'($urandom_range(10, 15)));
          default: set_level(4'd0);
        endcase
      end
      drv_idle_on = $urandom_range(0, 2) != 0;
      rx_idle_on  = $urandom_range(0, 2) != 0;
      // long hold-off with the sender flat out, so in_tready has to drop
      if (first || $urandom_range(0, 7) == 0) begin
        drv_idle_on = 1'b0;
        hold_reqs++;
      end
      first = 1'b0;
      lv = det_level - 1;

      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 30))
          add_sample(13'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)));
      end else begin
        // free-fall run around the level's length; a short one breaks the sequence
        run = int'(fds_pkg::FF_TICKS[lv]) + int'($urandom_range(0, 5)) - 2;
        ff_last = '0;
        for (int i = 0; i < run; i++) begin
          case ($urandom_range(0, 3))
            0:       m = '0;
            1:       m = fds_pkg::FF_THRESH[lv] - 1'b1;
            default: m = 13'($urandom_range(0, fds_pkg::FF_THRESH[lv] - 1));
          endcase
          add_sample(m, 1'($urandom_range(0, 1)));
          ff_last = m;
        end
        // impact wait, now and then across the 1 s limit
        waits = ($urandom_range(0, 9) == 0) ? $urandom_range(95, 105) : $urandom_range(0, 20);
        repeat (waits)
          add_sample(13'($urandom_range(0, fds_pkg::IMPACT_LEVEL - 1)),
                     1'($urandom_range(0, 1)));
        add_sample(13'($urandom_range(fds_pkg::IMPACT_LEVEL, 8191)), 1'($urandom_range(0, 1)));
        // rest stretch; the long noisy one runs out the 4 s window
        if ($urandom_range(0, 19) == 0) begin
          rlen    = $urandom_range(400, 410);
          bad_pct = 50;
        end else begin
          rlen    = $urandom_range(215, 260);
          bad_pct = 4;
        end
        repeat (rlen) begin
          if ($urandom_range(0, 99) < bad_pct) begin
            case ($urandom_range(0, 2))
              0: add_sample(13'($urandom_range(ff_last + fds_pkg::RISE_MIN,
                                               fds_pkg::REST_THRESH[lv] - 1)), 1'b0);
              1: add_sample(13'($urandom_range(fds_pkg::REST_THRESH[lv], 8191)), 1'b1);
              default: add_sample(13'($urandom_range(0, ff_last + fds_pkg::RISE_MIN - 1)),
                                  1'b1);
            endcase
          end else begin
            add_sample(13'($urandom_range(ff_last + fds_pkg::RISE_MIN,
                                          fds_pkg::REST_THRESH[lv] - 1)), 1'b1);
          end
        end
        repeat ($urandom_range(1, 3))
          add_sample(13'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)));
      end
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // run limit: far beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
